// ===== rtl/kapq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keyframe-aware packet queue.
// No dependencies; imported by the interfaces, kapq_ctrl and the top level.
package kapq_pkg;

  // Store geometry; the depth must be a power of two (pointers wrap).
  localparam int QUEUE_DEPTH  = 256;
  localparam int HANDLE_WIDTH = 32;
  localparam int ADDR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int ENTRY_W      = HANDLE_WIDTH + 1;   // {keyframe, handle}

  localparam int LIMIT_W      = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  // Fixed result widths.
  localparam int STATUS_W = 2;
  localparam int DROP_W   = 9;

  // Request opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_POP_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [HANDLE_WIDTH-1:0] popped_handle;
    logic                    popped_keyframe;
    logic [DROP_W-1:0]       dropped_count;
    logic [CNT_W-1:0]        occupancy;
  } kapq_result_t;

endpackage

// ===== rtl/kapq_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready handshake).
// Depends on kapq_pkg.
interface kapq_in_if import kapq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [HANDLE_WIDTH-1:0] buffer_handle;
  logic                    is_keyframe;

  modport source (output valid, opcode, buffer_handle, is_keyframe, input ready);
  modport sink   (input valid, opcode, buffer_handle, is_keyframe, output ready);
endinterface

interface kapq_out_if import kapq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [HANDLE_WIDTH-1:0] popped_handle;
  logic                    popped_keyframe;
  logic [DROP_W-1:0]       dropped_count;
  logic [CNT_W-1:0]        occupancy;

  modport source (output valid, status, popped_handle, popped_keyframe, dropped_count,
                  occupancy, input ready);
  modport sink   (input valid, status, popped_handle, popped_keyframe, dropped_count,
                  occupancy, output ready);
endinterface

// ===== rtl/keyframe_aware_packet_queue.sv =====
`timescale 1ns / 1ps
// Top level of the keyframe-aware packet queue: sequencer, descriptor RAM
// and result register. Depends on kapq_pkg, kapq_if, kapq_ram, kapq_ctrl.
//
// Usage
//   cmd  : request channel (valid/ready). opcode 0 pushes {buffer_handle,
//          is_keyframe}, opcode 1 pops the oldest descriptor.
//   rsp  : one result per request: status, popped descriptor, number of
//          entries dropped by a push, and occupancy after the request.
//   cfg  : cfg_we/cfg_data write queue_limit; write only while idle.
// Sequence (request accept to result valid)
//   an empty pop goes straight to the result; a pop reads the head slot
//   first; a push writes its slot, checks the limit and, above it, runs a
//   drop walk over the entries it drops, plus the keyframe it stops at
//   when non-keyframes went first. The drop walk reads one descriptor per
//   cycle from the single read port of the ring RAM, which sets the push
//   cost. The sequencer takes the next request the cycle after its result
//   moves to the output register.
// Reset (rst, synchronous): queue empty, head at slot 0, limit = 100.
//   Ring contents are not cleared; only pushed slots are ever read.
// Backpressure: the result sits in an output register; the next request is
//   accepted while it waits, and the sequencer holds its own finished result
//   until the register frees up.
module keyframe_aware_packet_queue import kapq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  kapq_in_if.sink            cmd,
  kapq_out_if.source         rsp
);

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic               res_valid;
  logic               res_ready;
  kapq_result_t       res;

  // Output stage
  logic               out_valid;
  kapq_result_t       out_res;

  kapq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  kapq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Register takes a new result when empty or being drained this cycle.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_res.status;
  assign rsp.popped_handle   = out_res.popped_handle;
  assign rsp.popped_keyframe = out_res.popped_keyframe;
  assign rsp.dropped_count   = out_res.dropped_count;
  assign rsp.occupancy       = out_res.occupancy;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_res)))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.status == ST_POP_OK || out_res.status == ST_POP_EMPTY ||
                   out_res.status == ST_PUSH_OK))
    else $error("undefined status code");

  a_pop_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != ST_PUSH_OK) |-> out_res.dropped_count == '0)
    else $error("pop result reports dropped entries");

endmodule

// ===== rtl/kapq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kapq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/kapq_ctrl.sv =====
`timescale 1ns / 1ps
// Queue sequencer: pointers, limit register, push/pop handling and drop walk.
// Depends on kapq_pkg and kapq_in_if; drives the descriptor RAM ports.
module kapq_ctrl import kapq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_data,
  kapq_in_if.sink             cmd,
  output logic                ram_wr_en,
  output logic [ADDR_W-1:0]   ram_wr_addr,
  output logic [ENTRY_W-1:0]  ram_wr_data,
  output logic                ram_rd_en,
  output logic [ADDR_W-1:0]   ram_rd_addr,
  input  logic [ENTRY_W-1:0]  ram_rd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output kapq_result_t        res
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_POP_RD   = 3'd1;
  localparam logic [2:0] S_PUSH_CHK = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]              state, state_next;
  logic [ADDR_W-1:0]       head, head_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [LIMIT_W-1:0]      limit;
  logic                    first, first_next;
  logic [STATUS_W-1:0]     status, status_next;
  logic [HANDLE_WIDTH-1:0] ph, ph_next;
  logic                    pk, pk_next;
  logic [DROP_W-1:0]       dropped, dropped_next;

  logic                    front_key;
  logic                    full;
  logic [CNT_W-1:0]        count_dec;

  assign front_key = ram_rd_data[HANDLE_WIDTH];
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign count_dec = count - CNT_W'(1);

  always_comb begin
    state_next   = state;
    head_next    = head;
    count_next   = count;
    first_next   = first;
    status_next  = status;
    ph_next      = ph;
    pk_next      = pk;
    dropped_next = dropped;
    cmd.ready    = 1'b0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = head + count[ADDR_W-1:0];
    ram_wr_data  = {cmd.is_keyframe, cmd.buffer_handle};
    ram_rd_en    = 1'b0;
    ram_rd_addr  = head;
    res_valid    = 1'b0;

    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          ph_next      = '0;
          pk_next      = 1'b0;
          dropped_next = '0;
          if (cmd.opcode == OP_POP) begin
            if (count == '0) begin
              status_next = ST_POP_EMPTY;
              state_next  = S_DONE;
            end else begin
              status_next = ST_POP_OK;
              ram_rd_en   = 1'b1;
              state_next  = S_POP_RD;
            end
          end else begin
            // Full store: the slot at head+count is the head slot, so the
            // oldest entry is overwritten and counted as dropped.
            status_next = ST_PUSH_OK;
            ram_wr_en   = 1'b1;
            if (full) begin
              head_next    = head + ADDR_W'(1);
              dropped_next = DROP_W'(1);
            end else begin
              count_next = count + CNT_W'(1);
            end
            state_next = S_PUSH_CHK;
          end
        end
      end
      S_POP_RD: begin
        ph_next    = ram_rd_data[HANDLE_WIDTH-1:0];
        pk_next    = front_key;
        head_next  = head + ADDR_W'(1);
        count_next = count_dec;
        state_next = S_DONE;
      end
      S_PUSH_CHK: begin
        if (count > {1'b0, limit}) begin
          ram_rd_en  = 1'b1;
          first_next = 1'b1;
          state_next = S_WALK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        first_next = 1'b0;
        if (front_key && !first) begin
          state_next = S_DONE;
        end else begin
          head_next    = head + ADDR_W'(1);
          count_next   = count_dec;
          dropped_next = dropped + DROP_W'(1);
          if (front_key || count_dec == '0) begin
            state_next = S_DONE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = head + ADDR_W'(1);
          end
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      limit <= LIMIT_RESET;
      first <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      first <= first_next;
      if (cfg_we) begin
        limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status  <= status_next;
    ph      <= ph_next;
    pk      <= pk_next;
    dropped <= dropped_next;
  end

  assign res = '{status:          status,
                 popped_handle:   ph,
                 popped_keyframe: pk,
                 dropped_count:   dropped,
                 occupancy:       count};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above store depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_wr_en && ram_rd_en))
    else $error("RAM read and write in the same cycle");

  a_write_on_push: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == S_IDLE && cmd.valid && cmd.opcode == OP_PUSH))
    else $error("RAM write outside push acceptance");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_RD |=> count == $past(count_dec))
    else $error("pop did not decrement the count");

  a_walk_read: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> $past(ram_rd_en))
    else $error("walk step without a pending front read");

endmodule
